>>> rtl/core/lsc_pkg.sv
// Shared types and constants for the layered LRU slot cache.
// No dependencies; every other source file but lsc_ram refers to this package by scoped name.
package lsc_pkg;

   // result status codes
   localparam logic [1:0] STATUS_HIT    = 2'd0;
   localparam logic [1:0] STATUS_PAGEIN = 2'd1;
   localparam logic [1:0] STATUS_REJECT = 2'd2;

   // configuration register indexes (byte address = 4 * index)
   localparam logic [1:0] REG_NUM_LAYERS   = 2'd0;
   localparam logic [1:0] REG_NUM_EXPERTS  = 2'd1;
   localparam logic [1:0] REG_SLOTS_IN_USE = 2'd2;
   localparam logic [1:0] REG_EXPERT_ELEMS = 2'd3;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam int LAYER_W  = 6;
   localparam int EXPERT_W = 9;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 4;
   localparam int COUNT_W  = 32;
   localparam int STAMP_W  = 48;
   localparam int BYTES_W  = 48;

   localparam logic [6:0]  RST_NUM_LAYERS   = 7'd64;
   localparam logic [9:0]  RST_NUM_EXPERTS  = 10'd512;
   localparam logic [4:0]  RST_SLOTS_IN_USE = 5'd16;
   localparam logic [30:0] RST_EXPERT_ELEMS = 31'd0;

   typedef struct packed {
      logic [6:0]  num_layers;
      logic [9:0]  num_experts;
      logic [4:0]  slots_in_use;
      logic [30:0] expert_elems;
   } cfg_type;

   // one slot of a layer row
   typedef struct packed {
      logic                valid;
      logic [EXPERT_W-1:0] tag;
      logic [STAMP_W-1:0]  stamp;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic accept;
      logic read;
      logic load;
      logic reduce;
      logic commit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic req_bad;
      logic out_free;
   } stat_type;

endpackage

>>> rtl/core/lsc_req_if.sv
// Request channel: valid/ready handshake carrying layer and expert.
// Depends on lsc_pkg for field widths.
interface lsc_req_if;
   logic                          valid;
   logic                          ready;
   logic [lsc_pkg::LAYER_W-1:0]   layer;
   logic [lsc_pkg::EXPERT_W-1:0]  expert;

   modport source (output valid, output layer, output expert, input ready);
   modport sink   (input valid, input layer, input expert, output ready);
endinterface

>>> rtl/core/lsc_rsp_if.sv
// Response channel: valid/ready handshake carrying one lookup result.
// Depends on lsc_pkg for field widths.
interface lsc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lsc_pkg::STATUS_W-1:0]  status;
   logic [lsc_pkg::SLOT_W-1:0]    slot;
   logic                          evicted_valid;
   logic [lsc_pkg::EXPERT_W-1:0]  evicted_expert;
   logic [lsc_pkg::COUNT_W-1:0]   hit_count;
   logic [lsc_pkg::COUNT_W-1:0]   pagein_count;
   logic [lsc_pkg::BYTES_W-1:0]   byte_count;

   modport source (output valid, output status, output slot, output evicted_valid,
                   output evicted_expert, output hit_count, output pagein_count,
                   output byte_count, input ready);
   modport sink   (input valid, input status, input slot, input evicted_valid,
                   input evicted_expert, input hit_count, input pagein_count,
                   input byte_count, output ready);
endinterface

>>> rtl/core/lsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lsc_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> rtl/core/lsc_csr.sv
// APB-style configuration registers of the slot cache.
// Depends on lsc_pkg (register indexes, reset values, cfg_type).
module lsc_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lsc_pkg::CSR_AW-1:0]  paddr,
   input  logic [lsc_pkg::CSR_DW-1:0]  pwdata,
   output logic [lsc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   output lsc_pkg::cfg_type            cfg
);
   lsc_pkg::cfg_type cfg_ff, cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            lsc_pkg::REG_NUM_LAYERS:   cfg_in.num_layers   = pwdata[6:0];
            lsc_pkg::REG_NUM_EXPERTS:  cfg_in.num_experts  = pwdata[9:0];
            lsc_pkg::REG_SLOTS_IN_USE: cfg_in.slots_in_use = pwdata[4:0];
            lsc_pkg::REG_EXPERT_ELEMS: cfg_in.expert_elems = pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_layers   <= lsc_pkg::RST_NUM_LAYERS;
         cfg_ff.num_experts  <= lsc_pkg::RST_NUM_EXPERTS;
         cfg_ff.slots_in_use <= lsc_pkg::RST_SLOTS_IN_USE;
         cfg_ff.expert_elems <= lsc_pkg::RST_EXPERT_ELEMS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         lsc_pkg::REG_NUM_LAYERS:   prdata = {25'd0, cfg_ff.num_layers};
         lsc_pkg::REG_NUM_EXPERTS:  prdata = {22'd0, cfg_ff.num_experts};
         lsc_pkg::REG_SLOTS_IN_USE: prdata = {27'd0, cfg_ff.slots_in_use};
         lsc_pkg::REG_EXPERT_ELEMS: prdata = {1'b0, cfg_ff.expert_elems};
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

>>> rtl/core/lsc_ctrl.sv
// Sequencer of the slot cache: accept, row read, load, min-tree levels, commit.
// Depends on lsc_pkg (cmd_type, stat_type).
module lsc_ctrl #(
   parameter int MAX_SLOTS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  lsc_pkg::stat_type  stat,
   output lsc_pkg::cmd_type   cmd
);
   localparam int LEVELS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 0;
   localparam int LVW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_READ   = 3'd1;
   localparam logic [2:0] ST_LOAD   = 3'd2;
   localparam logic [2:0] ST_REDUCE = 3'd3;
   localparam logic [2:0] ST_COMMIT = 3'd4;

   logic [2:0]     state_ff, state_in;
   logic [LVW-1:0] lvl_ff, lvl_in;

   always_comb begin
      state_in  = state_ff;
      lvl_in    = lvl_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.req_bad ? ST_COMMIT : ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            lvl_in   = '0;
            state_in = (LEVELS == 0) ? ST_COMMIT : ST_REDUCE;
         end
         ST_REDUCE: begin
            cmd.reduce = 1'b1;
            lvl_in     = lvl_ff + 1'b1;
            if (lvl_ff == LVW'(LEVELS - 1)) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait for the output register to free up
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lvl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
      end
   end
endmodule

>>> rtl/core/lsc_datapath.sv
// Slot cache datapath: row memory, hit search, min-stamp tree, counters, result reg.
// Depends on lsc_pkg, lsc_rsp_if and lsc_ram.
module lsc_datapath #(
   parameter int MAX_LAYERS = 64,
   parameter int MAX_SLOTS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lsc_pkg::cfg_type              cfg,
   input  logic [lsc_pkg::LAYER_W-1:0]   req_layer,
   input  logic [lsc_pkg::EXPERT_W-1:0]  req_expert,
   input  lsc_pkg::cmd_type              cmd,
   output lsc_pkg::stat_type             stat,
   lsc_rsp_if.source                     rsp
);
   localparam int ROW_AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
   localparam int LEVELS = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 0;
   localparam int TREE_N = 1 << LEVELS;
   localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int ENT_W  = $bits(lsc_pkg::entry_type);
   localparam int ROW_W  = MAX_SLOTS * ENT_W;
   localparam int NW     = 9;

   typedef lsc_pkg::entry_type [MAX_SLOTS-1:0] row_type;

   // request latched at accept
   logic [lsc_pkg::LAYER_W-1:0]  layer_ff, layer_in;
   logic [lsc_pkg::EXPERT_W-1:0] expert_ff, expert_in;
   logic                         reject_ff, reject_in;
   logic [ROW_AW-1:0]            row_addr;

   // row valid bits stand in for the reset value of never-written rows
   logic [MAX_LAYERS-1:0] row_vld_ff, row_vld_in;
   logic                  row_ok_ff, row_ok_in;

   logic [ROW_W-1:0] ram_rdata;
   logic [ROW_W-1:0] ram_wdata;
   row_type          row_eff, row_wr;

   logic [NW-1:0]        nslots;
   logic [MAX_SLOTS-1:0] slot_en;

   logic          hit_any;
   logic [SW-1:0] hit_idx;
   logic          hit_ff, hit_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in;

   logic [lsc_pkg::STAMP_W-1:0] cand_stamp_ff [TREE_N];
   logic [lsc_pkg::STAMP_W-1:0] cand_stamp_in [TREE_N];
   logic [SW-1:0]               cand_idx_ff [TREE_N];
   logic [SW-1:0]               cand_idx_in [TREE_N];
   logic [TREE_N-1:0]           cand_en_ff, cand_en_in;

   logic [lsc_pkg::STAMP_W-1:0] clock_ff, clock_in, new_stamp;
   logic [lsc_pkg::COUNT_W-1:0] hits_ff, hits_in, pageins_ff, pageins_in;
   logic [lsc_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [33:0]                 elems_ext, page_bytes;

   logic [SW-1:0]         widx;
   lsc_pkg::entry_type    old_ent, new_ent;

   logic                          out_vld_ff, out_vld_in;
   logic [lsc_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [lsc_pkg::SLOT_W-1:0]    out_slot_ff, out_slot_in;
   logic                          out_ev_vld_ff, out_ev_vld_in;
   logic [lsc_pkg::EXPERT_W-1:0]  out_ev_exp_ff, out_ev_exp_in;

   // ---- range check on the incoming request
   assign stat.req_bad =
      !(({1'b0, req_layer} < cfg.num_layers) &&
        ({3'd0, req_layer} < NW'(MAX_LAYERS)) &&
        ({1'b0, req_expert} < cfg.num_experts));
   assign stat.out_free = !out_vld_ff || rsp.ready;

   assign row_addr = ROW_AW'(layer_ff);

   // ---- row memory
   lsc_ram #(.WIDTH(ROW_W), .DEPTH(MAX_LAYERS)) u_row_ram (
      .clock (clock),
      .we    (cmd.commit && !reject_ff),
      .waddr (row_addr),
      .wdata (ram_wdata),
      .re    (cmd.read),
      .raddr (row_addr),
      .rdata (ram_rdata)
   );

   assign row_eff = row_ok_ff ? row_type'(ram_rdata) : row_type'('0);

   // ---- slots taking part: clamp count to [1, MAX_SLOTS]
   always_comb begin
      if (cfg.slots_in_use == '0) begin
         nslots = NW'(1);
      end else if ({4'd0, cfg.slots_in_use} > NW'(MAX_SLOTS)) begin
         nslots = NW'(MAX_SLOTS);
      end else begin
         nslots = {4'd0, cfg.slots_in_use};
      end
      for (int i = 0; i < MAX_SLOTS; i++) begin
         slot_en[i] = NW'(i) < nslots;
      end
   end

   // ---- first matching slot
   always_comb begin
      hit_any = 1'b0;
      hit_idx = '0;
      for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
         if (slot_en[i] && row_eff[i].valid && row_eff[i].tag == expert_ff) begin
            hit_any = 1'b1;
            hit_idx = SW'(i);
         end
      end
   end

   // ---- min-stamp tree: one level per reduce step, lower index wins ties
   always_comb begin
      cand_en_in = cand_en_ff;
      for (int i = 0; i < TREE_N; i++) begin
         cand_stamp_in[i] = cand_stamp_ff[i];
         cand_idx_in[i]   = cand_idx_ff[i];
      end
      if (cmd.load) begin
         for (int i = 0; i < TREE_N; i++) begin
            if (i < MAX_SLOTS) begin
               cand_stamp_in[i] = row_eff[i].stamp;
               cand_idx_in[i]   = SW'(i);
               cand_en_in[i]    = slot_en[i];
            end else begin
               cand_stamp_in[i] = '0;
               cand_idx_in[i]   = '0;
               cand_en_in[i]    = 1'b0;
            end
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < TREE_N / 2; i++) begin
            if (cand_en_ff[2*i+1] &&
                (!cand_en_ff[2*i] || cand_stamp_ff[2*i+1] < cand_stamp_ff[2*i])) begin
               cand_stamp_in[i] = cand_stamp_ff[2*i+1];
               cand_idx_in[i]   = cand_idx_ff[2*i+1];
               cand_en_in[i]    = 1'b1;
            end else begin
               cand_stamp_in[i] = cand_stamp_ff[2*i];
               cand_idx_in[i]   = cand_idx_ff[2*i];
               cand_en_in[i]    = cand_en_ff[2*i];
            end
         end
      end
   end

   // ---- commit: row update, counters, result
   assign new_stamp  = clock_ff + 1'b1;
   assign elems_ext  = 34'(cfg.expert_elems);
   assign page_bytes = (elems_ext << 2) + (elems_ext << 1);
   assign widx       = hit_ff ? hit_idx_ff : cand_idx_ff[0];
   assign old_ent    = row_eff[widx];

   always_comb begin
      new_ent       = old_ent;
      new_ent.stamp = new_stamp;
      if (!hit_ff) begin
         new_ent.valid = 1'b1;
         new_ent.tag   = expert_ff;
      end
      row_wr       = row_eff;
      row_wr[widx] = new_ent;
   end
   assign ram_wdata = ROW_W'(row_wr);

   always_comb begin
      layer_in      = layer_ff;
      expert_in     = expert_ff;
      reject_in     = reject_ff;
      row_ok_in     = row_ok_ff;
      row_vld_in    = row_vld_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      clock_in      = clock_ff;
      hits_in       = hits_ff;
      pageins_in    = pageins_ff;
      bytes_in      = bytes_ff;
      out_vld_in    = out_vld_ff && !rsp.ready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_ev_vld_in = out_ev_vld_ff;
      out_ev_exp_in = out_ev_exp_ff;

      if (cmd.accept) begin
         layer_in  = req_layer;
         expert_in = req_expert;
         reject_in = stat.req_bad;
      end
      if (cmd.read) begin
         row_ok_in = row_vld_ff[row_addr];
      end
      if (cmd.load) begin
         hit_in     = hit_any;
         hit_idx_in = hit_idx;
      end
      if (cmd.commit) begin
         out_vld_in    = 1'b1;
         out_ev_vld_in = 1'b0;
         out_ev_exp_in = '0;
         if (reject_ff) begin
            out_status_in = lsc_pkg::STATUS_REJECT;
            out_slot_in   = '0;
         end else begin
            row_vld_in[row_addr] = 1'b1;
            clock_in             = new_stamp;
            out_slot_in          = lsc_pkg::SLOT_W'(widx);
            if (hit_ff) begin
               out_status_in = lsc_pkg::STATUS_HIT;
               hits_in       = hits_ff + 1'b1;
            end else begin
               out_status_in = lsc_pkg::STATUS_PAGEIN;
               out_ev_vld_in = old_ent.valid;
               out_ev_exp_in = old_ent.valid ? old_ent.tag : '0;
               pageins_in    = pageins_ff + 1'b1;
               bytes_in      = bytes_ff + lsc_pkg::BYTES_W'(page_bytes);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         clock_ff   <= '0;
         hits_ff    <= '0;
         pageins_ff <= '0;
         bytes_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         row_vld_ff <= row_vld_in;
         clock_ff   <= clock_in;
         hits_ff    <= hits_in;
         pageins_ff <= pageins_in;
         bytes_ff   <= bytes_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff      <= layer_in;
      expert_ff     <= expert_in;
      reject_ff     <= reject_in;
      row_ok_ff     <= row_ok_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      cand_en_ff    <= cand_en_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_ev_vld_ff <= out_ev_vld_in;
      out_ev_exp_ff <= out_ev_exp_in;
      for (int i = 0; i < TREE_N; i++) begin
         cand_stamp_ff[i] <= cand_stamp_in[i];
         cand_idx_ff[i]   <= cand_idx_in[i];
      end
   end

   assign rsp.valid          = out_vld_ff;
   assign rsp.status         = out_status_ff;
   assign rsp.slot           = out_slot_ff;
   assign rsp.evicted_valid  = out_ev_vld_ff;
   assign rsp.evicted_expert = out_ev_exp_ff;
   assign rsp.hit_count      = hits_ff;
   assign rsp.pagein_count   = pageins_ff;
   assign rsp.byte_count     = bytes_ff;
endmodule

>>> rtl/core/layered_lru_slot_cache.sv
// Layered LRU slot cache: one request at a time, L = ceil(log2(MAX_SLOTS)) min-tree levels.
// A request holds the block through row read, load, the L levels and commit, and commit stalls
// while the output register is occupied; a rejected request skips straight to commit.
// The row memory port and the level-per-cycle min tree set this sequence.
// Synchronous active-high reset: counters, use clock and row valid bits clear at once,
// so every row reads as empty right away; configuration returns to 64/512/16/0.
module layered_lru_slot_cache #(
   parameter int MAX_LAYERS = 64,
   parameter int MAX_SLOTS  = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   lsc_req_if.sink                     req_bus,
   lsc_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lsc_pkg::CSR_AW-1:0]  paddr,
   input  logic [lsc_pkg::CSR_DW-1:0]  pwdata,
   output logic [lsc_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   lsc_pkg::cfg_type  cfg;
   lsc_pkg::cmd_type  cmd;
   lsc_pkg::stat_type stat;

   // Register file. Writes are only expected while no request is in flight,
   // so the datapath reads the live values without a shadow copy.
   lsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer. Ready only in idle; an out-of-range request skips the row
   // read and goes straight to commit, which writes nothing back.
   lsc_ctrl #(.MAX_SLOTS(MAX_SLOTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath. One memory row per layer holds every slot's tag and stamp.
   // Hit search is a parallel compare with a priority pick; the miss victim
   // comes from a pairwise min tree, one level per cycle. The result sits in
   // an output register, so the next request is taken while it waits and
   // only the commit step stalls if it is still occupied.
   lsc_datapath #(.MAX_LAYERS(MAX_LAYERS), .MAX_SLOTS(MAX_SLOTS)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_layer  (req_bus.layer),
      .req_expert (req_bus.expert),
      .cmd        (cmd),
      .stat       (stat),
      .rsp        (rsp_bus)
   );
endmodule

>>> rtl/core/lsc_checker.sv
// Port-level checks for layered_lru_slot_cache, attached by bind.
// Depends on lsc_pkg (status codes) and the top level's ports.
module lsc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [lsc_pkg::STATUS_W-1:0]  rsp_status,
   input logic [lsc_pkg::SLOT_W-1:0]    rsp_slot,
   input logic                          rsp_evicted_valid,
   input logic [lsc_pkg::EXPERT_W-1:0]  rsp_evicted_expert
);
   // response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_slot))
      else $error("response payload changed while stalled");

   // one request in flight: ready drops right after acceptance
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lsc_pkg::STATUS_REJECT |->
         rsp_slot == '0 && !rsp_evicted_valid && rsp_evicted_expert == '0)
      else $error("rejected request reports slot or eviction");

   a_evict_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted_valid |-> rsp_status == lsc_pkg::STATUS_PAGEIN)
      else $error("eviction reported without a page-in");
endmodule

bind layered_lru_slot_cache lsc_checker u_lsc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_status         (rsp_bus.status),
   .rsp_slot           (rsp_bus.slot),
   .rsp_evicted_valid  (rsp_bus.evicted_valid),
   .rsp_evicted_expert (rsp_bus.evicted_expert)
);

>>> tb/lsc_tb_pkg.sv
// Verification package for the layered LRU slot cache: the response record and
// a scoreboard class that predicts each response from a shadow copy of the cache.
// Depends on lsc_pkg for field widths, status codes and register indexes.
package lsc_tb_pkg;

   localparam int TB_MAX_LAYERS = 64;
   localparam int TB_MAX_SLOTS  = 16;

   typedef struct packed {
      logic [lsc_pkg::STATUS_W-1:0] status;
      logic [lsc_pkg::SLOT_W-1:0]   slot;
      logic                         evicted_valid;
      logic [lsc_pkg::EXPERT_W-1:0] evicted_expert;
      logic [lsc_pkg::COUNT_W-1:0]  hit_count;
      logic [lsc_pkg::COUNT_W-1:0]  pagein_count;
      logic [lsc_pkg::BYTES_W-1:0]  byte_count;
   } lookup_result_type;

   class slot_cache_model_type;
      // shadow of the slot rows, counters and registers
      bit                           tag_valid  [TB_MAX_LAYERS*TB_MAX_SLOTS];
      bit [lsc_pkg::EXPERT_W-1:0]   tag_expert [TB_MAX_LAYERS*TB_MAX_SLOTS];
      bit [lsc_pkg::STAMP_W-1:0]    last_use   [TB_MAX_LAYERS*TB_MAX_SLOTS];
      bit [lsc_pkg::STAMP_W-1:0]    use_clock;
      bit [lsc_pkg::COUNT_W-1:0]    hits;
      bit [lsc_pkg::COUNT_W-1:0]    pageins;
      bit [lsc_pkg::BYTES_W-1:0]    bytes_fetched;
      bit [6:0]                     num_layers;
      bit [9:0]                     num_experts;
      bit [4:0]                     slots_in_use;
      bit [30:0]                    expert_elems;
      lookup_result_type            awaited[$];
      int unsigned                  mismatches;

      function new();
         num_layers   = lsc_pkg::RST_NUM_LAYERS;
         num_experts  = lsc_pkg::RST_NUM_EXPERTS;
         slots_in_use = lsc_pkg::RST_SLOTS_IN_USE;
         expert_elems = lsc_pkg::RST_EXPERT_ELEMS;
      endfunction

      function int active_slots();
         if (slots_in_use < 1) return 1;
         if (slots_in_use > TB_MAX_SLOTS) return TB_MAX_SLOTS;
         return int'(slots_in_use);
      endfunction

      function void write_reg(logic [1:0] index, logic [31:0] value);
         case (index)
            lsc_pkg::REG_NUM_LAYERS:   num_layers   = value[6:0];
            lsc_pkg::REG_NUM_EXPERTS:  num_experts  = value[9:0];
            lsc_pkg::REG_SLOTS_IN_USE: slots_in_use = value[4:0];
            lsc_pkg::REG_EXPERT_ELEMS: expert_elems = value[30:0];
            default: ;
         endcase
      endfunction

      // lookup and update for one accepted request; queues the response it must give
      function void note_request(logic [lsc_pkg::LAYER_W-1:0] layer,
                                 logic [lsc_pkg::EXPERT_W-1:0] expert);
         lookup_result_type r;
         int lim, ns, base, s, victim;
         bit found;
         r = '0;
         r.status = lsc_pkg::STATUS_REJECT;
         lim = (num_layers < TB_MAX_LAYERS) ? int'(num_layers) : TB_MAX_LAYERS;
         if (layer < lim && expert < num_experts) begin
            ns = active_slots();
            base = layer * TB_MAX_SLOTS;
            found = 0;
            victim = 0;
            for (s = 0; s < ns; s++) begin
               if (!found && tag_valid[base+s] && tag_expert[base+s] == expert) begin
                  found = 1;
                  victim = s;
               end
            end
            use_clock++;
            if (found) begin
               last_use[base+victim] = use_clock;
               hits++;
               r.status = lsc_pkg::STATUS_HIT;
            end else begin
               // oldest stamp loses, lowest index on a tie
               for (s = 1; s < ns; s++) begin
                  if (last_use[base+s] < last_use[base+victim]) victim = s;
               end
               if (tag_valid[base+victim]) begin
                  r.evicted_valid  = 1'b1;
                  r.evicted_expert = tag_expert[base+victim];
               end
               bytes_fetched = bytes_fetched + {17'd0, expert_elems} * 48'd6;
               pageins++;
               tag_valid[base+victim]  = 1'b1;
               tag_expert[base+victim] = expert;
               last_use[base+victim]   = use_clock;
               r.status = lsc_pkg::STATUS_PAGEIN;
            end
            r.slot = victim[lsc_pkg::SLOT_W-1:0];
         end
         r.hit_count    = hits;
         r.pagein_count = pageins;
         r.byte_count   = bytes_fetched;
         awaited.push_back(r);
      endfunction

      function void check_result(lookup_result_type got);
         lookup_result_type want;
         if (awaited.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot);
            mismatches++;
         end
         if (got.evicted_valid !== want.evicted_valid) begin
            $error("evicted_valid: expected %0d, got %0d", want.evicted_valid,
                   got.evicted_valid);
            mismatches++;
         end
         if (got.evicted_expert !== want.evicted_expert) begin
            $error("evicted_expert: expected %0d, got %0d", want.evicted_expert,
                   got.evicted_expert);
            mismatches++;
         end
         if (got.hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, got %0d", want.hit_count, got.hit_count);
            mismatches++;
         end
         if (got.pagein_count !== want.pagein_count) begin
            $error("pagein_count: expected %0d, got %0d", want.pagein_count,
                   got.pagein_count);
            mismatches++;
         end
         if (got.byte_count !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count, got.byte_count);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

endpackage

>>> tb/testbench.sv
// Top-level testbench for layered_lru_slot_cache: directed and random lookups
// under several register settings and idle/stall patterns, checked by lsc_tb_pkg.
// Depends on lsc_pkg, lsc_req_if, lsc_rsp_if, lsc_tb_pkg and the cache RTL.
module testbench;

   localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
   localparam int HOLD_OFF       = 400;   // long receiver hold-off, fills the block
   localparam int DRAIN_CYCLES   = 12;    // margin after the last response

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         psel;
   logic                         penable;
   logic                         pwrite;
   logic [lsc_pkg::CSR_AW-1:0]   paddr;
   logic [lsc_pkg::CSR_DW-1:0]   pwdata;
   logic [lsc_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   lsc_req_if req_bus ();
   lsc_rsp_if rsp_bus ();

   lsc_tb_pkg::slot_cache_model_type model;
   lsc_tb_pkg::lookup_result_type    seen_rsp;

   int send_idle_pct = 0;   // chance the sender idles after a request
   int stall_pct     = 0;   // chance the receiver stalls a cycle
   int hold_asks     = 0;   // bumped by the stimulus to ask for a hold-off
   int hold_seen     = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   layered_lru_slot_cache #(
      .MAX_LAYERS(lsc_tb_pkg::TB_MAX_LAYERS),
      .MAX_SLOTS (lsc_tb_pkg::TB_MAX_SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, plus a long hold-off counted here when asked for.
   // The ask arrives by nonblocking update, so it is seen at the next edge, no race.
   always @(posedge clock) begin
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = HOLD_OFF;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: requests and responses are sampled at the edge, before any
   // nonblocking update lands. A request is noted before a response is checked,
   // so a same-edge response still pairs with the oldest request.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles++;
         if (req_bus.valid && req_bus.ready) begin
            model.note_request(req_bus.layer, req_bus.expert);
            quiet_cycles = 0;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.status         = rsp_bus.status;
            seen_rsp.slot           = rsp_bus.slot;
            seen_rsp.evicted_valid  = rsp_bus.evicted_valid;
            seen_rsp.evicted_expert = rsp_bus.evicted_expert;
            seen_rsp.hit_count      = rsp_bus.hit_count;
            seen_rsp.pagein_count   = rsp_bus.pagein_count;
            seen_rsp.byte_count     = rsp_bus.byte_count;
            model.check_result(seen_rsp);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Offer one request and hold it until accepted; then maybe idle a while.
   // valid stays high into the next call when there is no gap.
   task automatic send_request(input logic [lsc_pkg::LAYER_W-1:0] layer,
                               input logic [lsc_pkg::EXPERT_W-1:0] expert);
      req_bus.valid  <= 1'b1;
      req_bus.layer  <= layer;
      req_bus.expert <= expert;
      do @(posedge clock); while (!req_bus.ready);
      if ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Stop offering, wait for every response (the write-back lands with it), then
   // drain as a margin before anything else touches the block.
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      while (model.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup then access; psel is left high so back-to-back writes never
   // lower and raise it in the same step.
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model.write_reg(index, value);
   endtask

   // Write all four registers while idle; junk in the upper bits checks masking.
   task automatic set_config(input logic [6:0] layers, input logic [9:0] experts,
                             input logic [4:0] slots, input logic [30:0] elems);
      quiesce();
      csr_write(lsc_pkg::REG_NUM_LAYERS,   {25'($urandom), layers});
      csr_write(lsc_pkg::REG_NUM_EXPERTS,  {22'($urandom), experts});
      csr_write(lsc_pkg::REG_SLOTS_IN_USE, {27'($urandom), slots});
      csr_write(lsc_pkg::REG_EXPERT_ELEMS, {1'($urandom), elems});
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_idling(input int send_pct, input int stall);
      send_idle_pct = send_pct;
      stall_pct    <= stall;
   endtask

   // Mostly a hot working set (few layers, ~1.5x the slot count in experts)
   // so hits, LRU refreshes and evictions dominate; the rest is anything.
   task automatic run_random(input int count);
      int i, span;
      logic [lsc_pkg::LAYER_W-1:0]  layer;
      logic [lsc_pkg::EXPERT_W-1:0] expert;
      for (i = 0; i < count; i++) begin
         span = model.active_slots() + model.active_slots() / 2 + 1;
         if ($urandom_range(99) < 80) begin
            layer  = 6'($urandom_range(3));
            expert = 9'($urandom_range(span));
         end else begin
            layer  = 6'($urandom_range(63));
            expert = 9'($urandom_range(511));
         end
         send_request(layer, expert);
      end
   endtask

   initial begin
      model = new();
      req_bus.valid  <= 1'b0;
      req_bus.layer  <= '0;
      req_bus.expert <= '0;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: miss into empty slot, hit, widest fields
      send_request(6'd0, 9'd0);
      send_request(6'd0, 9'd0);
      send_request(6'd63, 9'd511);
      send_request(6'd63, 9'd511);
      send_request(6'd9, 9'd10);
      send_request(6'd9, 9'd11);
      send_request(6'd9, 9'd12);

      // one slot searched: 12 sits in slot 2, unseen, so it misses and evicts 10
      set_config(7'd64, 10'd512, 5'd1, 31'h7FFF_FFFF);
      send_request(6'd9, 9'd12);
      send_request(6'd0, 9'd0);

      // counts above range act as the maximum; slot 1 kept its tag while hidden
      set_config(7'd127, 10'd1023, 5'd31, 31'd5);
      send_request(6'd9, 9'd11);
      send_request(6'd9, 9'd12);
      send_request(6'd63, 9'd1);

      // layer and expert limits; zero slots acts as one
      set_config(7'd3, 10'd5, 5'd0, 31'd1);
      send_request(6'd3, 9'd0);
      send_request(6'd2, 9'd5);
      send_request(6'd2, 9'd4);
      send_request(6'd2, 9'd4);
      send_request(6'd2, 9'd3);

      // zero limits reject everything
      set_config(7'd0, 10'd512, 5'd16, 31'd1);
      send_request(6'd0, 9'd0);
      set_config(7'd64, 10'd0, 5'd16, 31'd1);
      send_request(6'd0, 9'd0);

      // two-way LRU: refresh keeps 1, then 2 and 1 are evicted in turn
      set_config(7'd64, 10'd512, 5'd2, 31'd2);
      send_request(6'd5, 9'd1);
      send_request(6'd5, 9'd2);
      send_request(6'd5, 9'd1);
      send_request(6'd5, 9'd3);
      send_request(6'd5, 9'd4);

      // back-to-back, with a long receiver hold-off so the input backs up
      set_config(7'd64, 10'd512, 5'd4, 31'($urandom_range(1000)));
      set_idling(0, 0);
      hold_asks <= hold_asks + 1;
      run_random(100);

      // extremes, sender mostly idle
      set_config(7'd127, 10'd1023, 5'd31, 31'h7FFF_FFFF);
      set_idling(88, 0);
      run_random(100);

      // random limits, receiver mostly stalling
      set_config(7'($urandom_range(64, 4)), 10'($urandom_range(512, 16)),
                 5'($urandom_range(16, 0)), 31'($urandom));
      set_idling(0, 88);
      run_random(100);

      // full size, light idling on both sides
      set_config(7'd64, 10'd512, 5'd16, 31'($urandom_range(100000)));
      set_idling(11, 11);
      run_random(100);

      quiesce();
      if (model.mismatches == 0 && model.outstanding() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/lsc_pkg.sv
rtl/core/lsc_req_if.sv
rtl/core/lsc_rsp_if.sv
rtl/core/lsc_ram.sv
rtl/core/lsc_csr.sv
rtl/core/lsc_ctrl.sv
rtl/core/lsc_datapath.sv
rtl/core/layered_lru_slot_cache.sv
rtl/core/lsc_checker.sv
tb/lsc_tb_pkg.sv
tb/testbench.sv
